@@ hw/rtl/mpps_pkg.sv @@
// ----------------------------------------------------------------------------
// mpps_pkg
// Shared types and codes of the MIDI bank select / program change selector.
// ----------------------------------------------------------------------------
package mpps_pkg;

    localparam int PATCH_SLOTS_DEF = 16;

    // field widths fixed by the item format
    localparam int KIND_W       = 2;
    localparam int CHANNEL_W    = 4;
    localparam int CTRL_W       = 7;
    localparam int DATA_W       = 7;
    localparam int SLOT_IDX_W   = 4;
    localparam int BANK_W       = 16;
    localparam int PROGRAM_W    = 7;
    localparam int PATCH_SLOT_W = 4;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_CTRL_CHANGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROG_CHANGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SLOT_WRITE  = 2'd2;

    // bank select controllers
    localparam logic [CTRL_W-1:0] CC_BANK_MSB = 7'd0;
    localparam logic [CTRL_W-1:0] CC_BANK_LSB = 7'd32;

    // result actions
    localparam logic ACT_DEACTIVATE = 1'b0;
    localparam logic ACT_ACTIVATE   = 1'b1;

    // command queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_BANK_MSB,
        OP_BANK_LSB,
        OP_PROGRAM,
        OP_SLOT_WRITE
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [DATA_W-1:0]     value;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [BANK_W-1:0]     slot_bank;
        logic [PROGRAM_W-1:0]  slot_program;
        logic                  slot_valid;
    } t_cmd;

endpackage

@@ hw/rtl/mpps_front.sv @@
// ----------------------------------------------------------------------------
// mpps_front
// Accepts MIDI items, filters by channel and controller, and turns the ones
// that matter into commands for the back end. Holds the listen channel.
// ----------------------------------------------------------------------------
module mpps_front #(
    parameter int PATCH_SLOTS = mpps_pkg::PATCH_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mpps_pkg::CHANNEL_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [mpps_pkg::KIND_W-1:0]      i_kind,
    input  logic [mpps_pkg::CHANNEL_W-1:0]   i_channel,
    input  logic [mpps_pkg::CTRL_W-1:0]      i_controller,
    input  logic [mpps_pkg::DATA_W-1:0]      i_data_value,
    input  logic [mpps_pkg::SLOT_IDX_W-1:0]  i_slot_index,
    input  logic [mpps_pkg::BANK_W-1:0]      i_slot_bank,
    input  logic [mpps_pkg::PROGRAM_W-1:0]   i_slot_program,
    input  logic                             i_slot_valid,
    input  logic                             i_full,
    output logic                             o_push,
    output mpps_pkg::t_cmd                   o_cmd
);

    logic [mpps_pkg::CHANNEL_W-1:0] r_listen_channel;
    logic                           chan_ok;
    logic                           keep;
    mpps_pkg::t_op                  op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_channel <= '0;
        end else if (i_cfg_valid) begin
            r_listen_channel <= i_cfg_data;
        end
    end

    assign chan_ok = (i_channel == r_listen_channel);

    always_comb begin
        keep = 1'b0;
        op   = mpps_pkg::OP_PROGRAM;
        unique case (i_kind)
            mpps_pkg::KIND_CTRL_CHANGE: begin
                if (chan_ok && i_controller == mpps_pkg::CC_BANK_MSB) begin
                    keep = 1'b1;
                    op   = mpps_pkg::OP_BANK_MSB;
                end else if (chan_ok && i_controller == mpps_pkg::CC_BANK_LSB) begin
                    keep = 1'b1;
                    op   = mpps_pkg::OP_BANK_LSB;
                end
            end
            mpps_pkg::KIND_PROG_CHANGE: begin
                keep = chan_ok;
                op   = mpps_pkg::OP_PROGRAM;
            end
            mpps_pkg::KIND_SLOT_WRITE: begin
                // slot writes ignore the channel; drop indexes past the table
                keep = (int'(i_slot_index) < PATCH_SLOTS);
                op   = mpps_pkg::OP_SLOT_WRITE;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full && keep;

    always_comb begin
        o_cmd.op           = op;
        o_cmd.value        = i_data_value;
        o_cmd.slot_index   = i_slot_index;
        o_cmd.slot_bank    = i_slot_bank;
        o_cmd.slot_program = i_slot_program;
        o_cmd.slot_valid   = i_slot_valid;
    end

endmodule

@@ hw/rtl/mpps_queue.sv @@
// ----------------------------------------------------------------------------
// mpps_queue
// Small command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mpps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpps_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output mpps_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);

    localparam int CNT_W = mpps_pkg::QUEUE_PTR_W + 1;

    mpps_pkg::t_cmd                      r_mem [mpps_pkg::QUEUE_DEPTH];
    logic [mpps_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [mpps_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]                    r_count;
    logic                                do_push;
    logic                                do_pop;

    assign o_full  = (r_count == CNT_W'(mpps_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers wrap on their own since the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/mpps_back.sv @@
// ----------------------------------------------------------------------------
// mpps_back
// Executes queued commands: bank byte updates, patch slot writes and the
// program change scan, which emits deactivate/activate items through an
// output register.
// ----------------------------------------------------------------------------
module mpps_back #(
    parameter int PATCH_SLOTS = mpps_pkg::PATCH_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  mpps_pkg::t_cmd                    i_cmd,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_action,
    output logic [mpps_pkg::PATCH_SLOT_W-1:0] o_patch_slot,
    output logic                              o_last
);

    localparam int IDX_W = (PATCH_SLOTS > 1) ? $clog2(PATCH_SLOTS) : 1;
    localparam int CNT_W = $clog2(PATCH_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT_ACT,
        ST_EMIT_DEACT,
        ST_FLUSH
    } t_state;

    logic [mpps_pkg::BANK_W-1:0]    r_bank_tbl [PATCH_SLOTS];
    logic [mpps_pkg::PROGRAM_W-1:0] r_prog_tbl [PATCH_SLOTS];
    logic [PATCH_SLOTS-1:0]         r_slot_vld;

    t_state                         r_state;
    logic [mpps_pkg::BANK_W-1:0]    r_cur_bank;
    logic [mpps_pkg::PROGRAM_W-1:0] r_prog;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_pend;
    logic                           r_act_present;
    logic [IDX_W-1:0]               r_act_idx;
    logic [IDX_W-1:0]               r_hit_idx;
    logic                           r_out_valid;
    logic                           r_out_action;
    logic [mpps_pkg::PATCH_SLOT_W-1:0] r_out_slot;
    logic                           r_out_last;

    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             scan_done;
    logic             hit;
    logic             out_free;
    logic             emit;
    logic             slot_wr;

    assign scan_idx  = r_cnt[IDX_W-1:0];
    assign wr_idx    = IDX_W'(i_cmd.slot_index);
    assign scan_done = (r_cnt == CNT_W'(PATCH_SLOTS));
    assign hit       = !scan_done && r_slot_vld[scan_idx]
                       && (r_bank_tbl[scan_idx] == r_cur_bank)
                       && (r_prog_tbl[scan_idx] == r_prog);
    assign out_free  = !r_out_valid || !i_stall;
    assign emit      = out_free && (r_state == ST_EMIT_ACT || r_state == ST_EMIT_DEACT
                                    || r_state == ST_FLUSH);
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign slot_wr   = o_pop && (i_cmd.op == mpps_pkg::OP_SLOT_WRITE);

    always_ff @(posedge i_clk) begin
        if (slot_wr) begin
            r_bank_tbl[wr_idx] <= i_cmd.slot_bank;
            r_prog_tbl[wr_idx] <= i_cmd.slot_program;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (slot_wr) begin
            r_slot_vld[wr_idx] <= i_cmd.slot_valid;
        end
    end

    // The activate item of a match is held back (r_pend) until the scan
    // knows whether a later match follows; that decides its last flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cur_bank    <= '0;
            r_prog        <= '0;
            r_cnt         <= '0;
            r_pend        <= 1'b0;
            r_act_present <= 1'b0;
            r_act_idx     <= '0;
            r_hit_idx     <= '0;
            r_out_valid   <= 1'b0;
            r_out_action  <= mpps_pkg::ACT_DEACTIVATE;
            r_out_slot    <= '0;
            r_out_last    <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        case (i_cmd.op)
                            mpps_pkg::OP_BANK_MSB: begin
                                r_cur_bank[15:8] <= {1'b0, i_cmd.value};
                            end
                            mpps_pkg::OP_BANK_LSB: begin
                                r_cur_bank[7:0] <= {1'b0, i_cmd.value};
                            end
                            mpps_pkg::OP_PROGRAM: begin
                                r_prog  <= i_cmd.value;
                                r_cnt   <= '0;
                                r_pend  <= 1'b0;
                                r_state <= ST_SCAN;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_done) begin
                        r_state <= r_pend ? ST_FLUSH : ST_IDLE;
                    end else if (hit) begin
                        r_hit_idx <= scan_idx;
                        if (r_pend) begin
                            r_state <= ST_EMIT_ACT;
                        end else if (r_act_present) begin
                            r_state <= ST_EMIT_DEACT;
                        end else begin
                            r_pend        <= 1'b1;
                            r_act_present <= 1'b1;
                            r_act_idx     <= scan_idx;
                            r_cnt         <= r_cnt + 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_EMIT_ACT: begin
                    if (out_free) begin
                        r_out_action <= mpps_pkg::ACT_ACTIVATE;
                        r_out_slot   <= mpps_pkg::PATCH_SLOT_W'(r_act_idx);
                        r_out_last   <= 1'b0;
                        r_state      <= ST_EMIT_DEACT;
                    end
                end
                ST_EMIT_DEACT: begin
                    if (out_free) begin
                        r_out_action  <= mpps_pkg::ACT_DEACTIVATE;
                        r_out_slot    <= mpps_pkg::PATCH_SLOT_W'(r_act_idx);
                        r_out_last    <= 1'b0;
                        r_pend        <= 1'b1;
                        r_act_present <= 1'b1;
                        r_act_idx     <= r_hit_idx;
                        r_cnt         <= r_cnt + 1'b1;
                        r_state       <= ST_SCAN;
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        r_out_action <= mpps_pkg::ACT_ACTIVATE;
                        r_out_slot   <= mpps_pkg::PATCH_SLOT_W'(r_act_idx);
                        r_out_last   <= 1'b1;
                        r_pend       <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_action     = r_out_action;
    assign o_patch_slot = r_out_slot;
    assign o_last       = r_out_last;

endmodule

@@ hw/rtl/midi_program_patch_selector_unit.sv @@
// ----------------------------------------------------------------------------
// midi_program_patch_selector_unit
// MIDI bank select / program change patch selector, top level.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_data (listen channel)
//   item in   in         i_valid/o_stall           kind, channel, ..., slot_valid
//   event out out        o_valid/i_stall           action, patch_slot, last
//
// Bank select and slot write are executed by the back end from its idle state;
// ignored items are dropped by the front. A program change scans the slot table
// one slot per cycle, pausing to emit the events of matches and on output
// stalls. The front queues up to two commands while the back end scans.
// Reset is synchronous; all slots come up invalid, bank 0, no active slot.
// ----------------------------------------------------------------------------
module midi_program_patch_selector_unit #(
    parameter int PATCH_SLOTS = mpps_pkg::PATCH_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mpps_pkg::CHANNEL_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [mpps_pkg::KIND_W-1:0]       i_kind,
    input  logic [mpps_pkg::CHANNEL_W-1:0]    i_channel,
    input  logic [mpps_pkg::CTRL_W-1:0]       i_controller,
    input  logic [mpps_pkg::DATA_W-1:0]       i_data_value,
    input  logic [mpps_pkg::SLOT_IDX_W-1:0]   i_slot_index,
    input  logic [mpps_pkg::BANK_W-1:0]       i_slot_bank,
    input  logic [mpps_pkg::PROGRAM_W-1:0]    i_slot_program,
    input  logic                              i_slot_valid,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_action,
    output logic [mpps_pkg::PATCH_SLOT_W-1:0] o_patch_slot,
    output logic                              o_last
);

    mpps_pkg::t_cmd push_cmd;
    mpps_pkg::t_cmd pop_cmd;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    mpps_front #(
        .PATCH_SLOTS(PATCH_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_controller   (i_controller),
        .i_data_value   (i_data_value),
        .i_slot_index   (i_slot_index),
        .i_slot_bank    (i_slot_bank),
        .i_slot_program (i_slot_program),
        .i_slot_valid   (i_slot_valid),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_cmd          (push_cmd)
    );

    mpps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mpps_back #(
        .PATCH_SLOTS(PATCH_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_cmd        (pop_cmd),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_action     (o_action),
        .o_patch_slot (o_patch_slot),
        .o_last       (o_last)
    );

    // the front must never hand the queue a command it cannot hold
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // a deactivate is always followed by an activate of the same program change
    a_deact_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == mpps_pkg::ACT_DEACTIVATE) |-> !o_last)
        else $error("deactivate item flagged as last");

    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // the back end only takes commands from a non-empty queue
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from an empty queue");

endmodule

@@ test/mpps_checker.sv @@
// ----------------------------------------------------------------------------
// mpps_checker
// Watches the config, item and event channels of the patch selector, keeps
// its own copy of bank, slot table and active slot, predicts the events of
// every accepted item and compares them in order with the events that leave.
// ----------------------------------------------------------------------------
module mpps_checker #(
    parameter int PATCH_SLOTS = mpps_pkg::PATCH_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [mpps_pkg::CHANNEL_W-1:0]    i_cfg_data,
    input  logic                              i_item_valid,
    input  logic                              i_item_stall,
    input  logic [mpps_pkg::KIND_W-1:0]       i_kind,
    input  logic [mpps_pkg::CHANNEL_W-1:0]    i_channel,
    input  logic [mpps_pkg::CTRL_W-1:0]       i_controller,
    input  logic [mpps_pkg::DATA_W-1:0]       i_data_value,
    input  logic [mpps_pkg::SLOT_IDX_W-1:0]   i_slot_index,
    input  logic [mpps_pkg::BANK_W-1:0]       i_slot_bank,
    input  logic [mpps_pkg::PROGRAM_W-1:0]    i_slot_program,
    input  logic                              i_slot_valid,
    input  logic                              i_ev_valid,
    input  logic                              i_ev_stall,
    input  logic                              i_action,
    input  logic [mpps_pkg::PATCH_SLOT_W-1:0] i_patch_slot,
    input  logic                              i_last,
    output int                                o_pending,
    output int                                o_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import mpps_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                    action;
        logic [PATCH_SLOT_W-1:0] slot;
        logic                    last;
    } t_patch_event;

    logic [CHANNEL_W-1:0]    listen_ch;
    logic [BANK_W-1:0]       cur_bank;
    logic [BANK_W-1:0]       bank_tab [PATCH_SLOTS];
    logic [PROGRAM_W-1:0]    prog_tab [PATCH_SLOTS];
    logic [PATCH_SLOTS-1:0]  slot_ok;
    logic                    have_active;
    logic [PATCH_SLOT_W-1:0] active_slot;
    t_patch_event            events_due[$];
    int                      mismatches = 0;

    function automatic logic slot_hit(input int s, input logic [PROGRAM_W-1:0] prog);
        return slot_ok[s] && bank_tab[s] == cur_bank && prog_tab[s] == prog;
    endfunction

    function automatic void push_event(input logic act, input logic [PATCH_SLOT_W-1:0] slot,
                                       input logic fin);
        t_patch_event ev;
        ev.action = act;
        ev.slot   = slot;
        ev.last   = fin;
        events_due.insert(events_due.size(), ev);
    endfunction

    // scan in slot order; every hit retires the active slot first, last hit wins
    function automatic void predict_program_change(input logic [PROGRAM_W-1:0] prog);
        int final_hit;
        final_hit = -1;
        for (int s = 0; s < PATCH_SLOTS; s++)
            if (slot_hit(s, prog)) final_hit = s;
        for (int s = 0; s < PATCH_SLOTS; s++) begin
            if (slot_hit(s, prog)) begin
                if (have_active) push_event(ACT_DEACTIVATE, active_slot, 1'b0);
                push_event(ACT_ACTIVATE, PATCH_SLOT_W'(s), s == final_hit);
                have_active = 1'b1;
                active_slot = PATCH_SLOT_W'(s);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_patch_event want;
        if (!i_rst_n) begin
            listen_ch   = '0;
            cur_bank    = '0;
            slot_ok     = '0;
            have_active = 1'b0;
            active_slot = '0;
            events_due.delete();
        end else begin
            // events leaving now belong to items accepted earlier
            if (i_ev_valid && !i_ev_stall) begin
                if (events_due.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected event action=%0d slot=%0d last=%0d",
                                 $time, i_action, i_patch_slot, i_last);
                    mismatches++;
                end else begin
                    want = events_due.pop_front();
                    if (want.action !== i_action || want.slot !== i_patch_slot ||
                        want.last !== i_last) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"%0t: event mismatch: expected action=%0d slot=%0d ",
                                      "last=%0d, got action=%0d slot=%0d last=%0d"},
                                     $time, want.action, want.slot, want.last,
                                     i_action, i_patch_slot, i_last);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) listen_ch = i_cfg_data;
            if (i_item_valid && !i_item_stall) begin
                case (i_kind)
                    KIND_CTRL_CHANGE: begin
                        if (i_channel == listen_ch) begin
                            if (i_controller == CC_BANK_MSB)
                                cur_bank[BANK_W-1:8] = {1'b0, i_data_value};
                            else if (i_controller == CC_BANK_LSB)
                                cur_bank[7:0] = {1'b0, i_data_value};
                        end
                    end
                    KIND_PROG_CHANGE: begin
                        if (i_channel == listen_ch) predict_program_change(i_data_value);
                    end
                    KIND_SLOT_WRITE: begin
                        if (i_slot_index < PATCH_SLOTS) begin
                            bank_tab[i_slot_index] = i_slot_bank;
                            prog_tab[i_slot_index] = i_slot_program;
                            slot_ok[i_slot_index]  = i_slot_valid;
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= events_due.size();
        o_errors  <= mismatches;
    end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Regression for the MIDI patch selector: a directed run through bank select,
// slot writes, ignored messages and repeated or rewritten active slots, then
// random phases over several listen channels. Input bursts and output stalls
// are random; the checker predicts and compares every event.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mpps_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 3;
    localparam int IDLE_LIMIT       = 2000;
    localparam int DRAIN_CYCLES     = 3 * (PATCH_SLOTS_DEF + 2) + 10;
    localparam int RANDOM_PER_PHASE = 60;
    localparam int PHASES           = 4;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_valid    = 1'b0;
    logic [CHANNEL_W-1:0]    i_cfg_data     = '0;
    logic                    i_valid        = 1'b0;
    logic [KIND_W-1:0]       i_kind         = '0;
    logic [CHANNEL_W-1:0]    i_channel      = '0;
    logic [CTRL_W-1:0]       i_controller   = '0;
    logic [DATA_W-1:0]       i_data_value   = '0;
    logic [SLOT_IDX_W-1:0]   i_slot_index   = '0;
    logic [BANK_W-1:0]       i_slot_bank    = '0;
    logic [PROGRAM_W-1:0]    i_slot_program = '0;
    logic                    i_slot_valid   = 1'b0;
    logic                    i_stall        = 1'b0;
    logic                    o_cfg_ready;
    logic                    o_stall;
    logic                    o_valid;
    logic                    o_action;
    logic [PATCH_SLOT_W-1:0] o_patch_slot;
    logic                    o_last;

    int pending;
    int errors;

    logic [CHANNEL_W-1:0] listen = '0;
    logic [DATA_W-1:0]    byte_pool [2];
    logic [PROGRAM_W-1:0] prog_pool [3];
    int                   burst_left = 0;
    int                   idle_cycles = 0;
    int                   stall_mode = 0;
    int                   stall_left = 0;
    logic [3:0]           stall_tick = '0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    midi_program_patch_selector_unit #(
        .PATCH_SLOTS (PATCH_SLOTS_DEF)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_controller   (i_controller),
        .i_data_value   (i_data_value),
        .i_slot_index   (i_slot_index),
        .i_slot_bank    (i_slot_bank),
        .i_slot_program (i_slot_program),
        .i_slot_valid   (i_slot_valid),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_action       (o_action),
        .o_patch_slot   (o_patch_slot),
        .o_last         (o_last)
    );

    mpps_checker #(
        .PATCH_SLOTS (PATCH_SLOTS_DEF)
    ) u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_item_valid   (i_valid),
        .i_item_stall   (o_stall),
        .i_kind         (i_kind),
        .i_channel      (i_channel),
        .i_controller   (i_controller),
        .i_data_value   (i_data_value),
        .i_slot_index   (i_slot_index),
        .i_slot_bank    (i_slot_bank),
        .i_slot_program (i_slot_program),
        .i_slot_valid   (i_slot_valid),
        .i_ev_valid     (o_valid),
        .i_ev_stall     (i_stall),
        .i_action       (o_action),
        .i_patch_slot   (o_patch_slot),
        .i_last         (o_last),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    // receiver stalls in modes: never, light, heavy, square wave
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= stall_tick[2];
        endcase
        stall_tick <= stall_tick + 4'd1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0]     kind,
                             input logic [CHANNEL_W-1:0]  chan,
                             input logic [CTRL_W-1:0]     ctl,
                             input logic [DATA_W-1:0]     val,
                             input logic [SLOT_IDX_W-1:0] sidx,
                             input logic [BANK_W-1:0]     sbank,
                             input logic [PROGRAM_W-1:0]  sprog,
                             input logic                  sval);
        int gap;
        i_kind         <= kind;
        i_channel      <= chan;
        i_controller   <= ctl;
        i_data_value   <= val;
        i_slot_index   <= sidx;
        i_slot_bank    <= sbank;
        i_slot_program <= sprog;
        i_slot_valid   <= sval;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // unused fields carry random values; the block must ignore them
    task automatic send_cc(input logic [CTRL_W-1:0] ctl, input logic [DATA_W-1:0] val);
        send_item(KIND_CTRL_CHANGE, listen, ctl, val, SLOT_IDX_W'($urandom),
                  BANK_W'($urandom), PROGRAM_W'($urandom), 1'($urandom));
    endtask

    task automatic send_program(input logic [PROGRAM_W-1:0] prog);
        send_item(KIND_PROG_CHANGE, listen, CTRL_W'($urandom), prog,
                  SLOT_IDX_W'($urandom), BANK_W'($urandom), PROGRAM_W'($urandom),
                  1'($urandom));
    endtask

    task automatic send_slot(input logic [SLOT_IDX_W-1:0] sidx, input logic [BANK_W-1:0] bank,
                             input logic [PROGRAM_W-1:0] prog, input logic sval);
        send_item(KIND_SLOT_WRITE, CHANNEL_W'($urandom), CTRL_W'($urandom), DATA_W'($urandom),
                  sidx, bank, prog, sval);
    endtask

    task automatic send_noise();
        logic [CTRL_W-1:0]    ctl;
        logic [CHANNEL_W-1:0] other;
        other = listen ^ CHANNEL_W'($urandom_range(1, 15));
        ctl   = CTRL_W'($urandom_range(1, 126));
        if (ctl == CC_BANK_LSB) ctl = ctl + 7'd1;
        case ($urandom_range(0, 3))
            0: send_item(KIND_CTRL_CHANGE, other,
                         ($urandom_range(0, 1) == 0) ? CC_BANK_MSB : CC_BANK_LSB,
                         DATA_W'($urandom), SLOT_IDX_W'($urandom), BANK_W'($urandom),
                         PROGRAM_W'($urandom), 1'($urandom));
            1: send_item(KIND_PROG_CHANGE, other, CTRL_W'($urandom), prog_pool[0],
                         SLOT_IDX_W'($urandom), BANK_W'($urandom), PROGRAM_W'($urandom),
                         1'($urandom));
            2: send_cc(ctl, DATA_W'($urandom));
            default: send_item(KIND_UNUSED, CHANNEL_W'($urandom), CTRL_W'($urandom),
                               DATA_W'($urandom), SLOT_IDX_W'($urandom), BANK_W'($urandom),
                               PROGRAM_W'($urandom), 1'($urandom));
        endcase
    endtask

    // small pools of banks and programs keep matches frequent
    task automatic send_random_item();
        int                   pick;
        logic [BANK_W-1:0]    bank;
        logic [PROGRAM_W-1:0] prog;
        pick = $urandom_range(0, 99);
        prog = ($urandom_range(0, 7) == 0) ? PROGRAM_W'($urandom)
                                           : prog_pool[$urandom_range(0, 2)];
        if (pick < 40) begin
            send_program(prog);
        end else if (pick < 60) begin
            send_cc(($urandom_range(0, 1) == 0) ? CC_BANK_MSB : CC_BANK_LSB,
                    ($urandom_range(0, 7) == 0) ? DATA_W'($urandom)
                                                : byte_pool[$urandom_range(0, 1)]);
        end else if (pick < 82) begin
            bank = {1'b0, byte_pool[$urandom_range(0, 1)], 1'b0, byte_pool[$urandom_range(0, 1)]};
            if ($urandom_range(0, 7) == 0) bank = BANK_W'($urandom);
            send_slot(SLOT_IDX_W'($urandom), bank, prog, $urandom_range(0, 7) != 0);
        end else begin
            send_noise();
        end
    endtask

    // every slot matches: one program change gives the longest event train
    task automatic fill_table_and_select();
        logic [BANK_W-1:0] bank;
        bank = {1'b0, byte_pool[0], 1'b0, byte_pool[1]};
        send_cc(CC_BANK_MSB, byte_pool[0]);
        send_cc(CC_BANK_LSB, byte_pool[1]);
        for (int s = 0; s < PATCH_SLOTS_DEF; s++)
            send_slot(SLOT_IDX_W'(s), bank, prog_pool[0], 1'b1);
        send_program(prog_pool[0]);
    endtask

    task automatic write_listen_channel(input logic [CHANNEL_W-1:0] ch);
        listen = ch;
        i_cfg_data  <= ch;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // events done, then room for queued items that give no event
    task automatic wait_idle();
        if (i_valid) i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_listen_channel(4'd0);

        send_program(7'd0);                             // empty table, no match
        send_item(KIND_UNUSED, '1, '1, '1, '1, '1, '1, 1'b1);
        send_slot(4'd0, 16'h0000, 7'd5, 1'b1);
        send_slot(4'd7, 16'h0000, 7'd5, 1'b1);
        send_slot(4'd15, 16'hffff, 7'd127, 1'b1);       // bank out of reach
        send_program(7'd5);                             // two hits, last one stays
        send_program(7'd5);                             // active slot hit again
        send_cc(CC_BANK_MSB, 7'd127);
        send_cc(CC_BANK_LSB, 7'd127);
        send_cc(7'd127, 7'd0);                          // not a bank controller
        send_item(KIND_CTRL_CHANGE, 4'd15, CC_BANK_MSB, 7'd0, '0, '0, '0, 1'b0);
        send_slot(4'd3, 16'h7f7f, 7'd127, 1'b1);
        send_item(KIND_PROG_CHANGE, 4'd15, '1, 7'd127, '1, '1, '1, 1'b1);
        send_program(7'd127);
        send_slot(4'd3, 16'h7f7f, 7'd127, 1'b0);        // invalidate the active slot
        send_slot(4'd12, 16'h7f7f, 7'd127, 1'b1);
        send_program(7'd127);                           // still retires slot 3
        send_program(7'd0);
        send_cc(CC_BANK_MSB, 7'd0);
        send_cc(CC_BANK_LSB, 7'd0);
        send_program(7'd5);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       write_listen_channel(4'd15);
                1:       write_listen_channel(CHANNEL_W'($urandom_range(1, 14)));
                2:       write_listen_channel(4'd0);
                default: write_listen_channel(CHANNEL_W'($urandom));
            endcase
            foreach (byte_pool[i]) byte_pool[i] = DATA_W'($urandom);
            foreach (prog_pool[i]) prog_pool[i] = PROGRAM_W'($urandom);
            fill_table_and_select();
            repeat (RANDOM_PER_PHASE) send_random_item();
        end

        wait_idle();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mpps_pkg.sv
hw/rtl/mpps_front.sv
hw/rtl/mpps_queue.sv
hw/rtl/mpps_back.sv
hw/rtl/midi_program_patch_selector_unit.sv
test/mpps_checker.sv
test/tb.sv
